/* rtl/soa_pkg.sv */
// Shared types and constants for the slab object allocator.
// No dependencies; imported by every module of the block.
package soa_pkg;

	localparam int NumSlabs = 16;
	localparam int SlabW    = 4;
	localparam int ObjW     = 10;
	localparam int HandleW  = SlabW + ObjW;
	localparam int CapW     = 11;
	localparam int CntW     = 5;
	localparam int LinkW    = SlabW + 1;
	localparam int MemDepth = NumSlabs << ObjW;

	localparam logic [LinkW-1:0] SlabNone = LinkW'(NumSlabs);
	localparam logic [CapW-1:0]  ObjNone  = CapW'(1 << ObjW);
	localparam logic [CapW-1:0]  CapMax   = CapW'(1 << ObjW);
	localparam logic [CapW-1:0]  CapReset = CapW'(1024);

	typedef enum logic [1:0] {
		TAG_UNUSED  = 2'd0,
		TAG_EMPTY   = 2'd1,
		TAG_PARTIAL = 2'd2,
		TAG_FULL    = 2'd3
	} tag_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_OOM = 2'd1,
		ST_BAD = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_SHRINK  = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_TAKE,
		S_WAIT,
		S_MOVE,
		S_DONE
	} bstate_t;

	typedef struct packed {
		op_t                op;
		logic [HandleW-1:0] handle;
	} cmd_t;

endpackage

/* rtl/soa_front.sv */
// Front end: input beat acceptance, function decode and a two-entry command queue.
// Depends on soa_pkg.
module soa_front import soa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic [HandleW-1:0] free_handle,
	output logic               cmd_valid,
	input  logic               cmd_ready,
	output cmd_t               cmd
);

	cmd_t       q_mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;
	cmd_t       dec;

	always_comb begin
		dec.handle = free_handle;
		dec.op     = op_t'(func);
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

/* rtl/soa_back.sv */
// Back end: slab lists, per-slab counters, object link memory, sequencer and result register.
// Depends on soa_pkg; fed by soa_front.
module soa_back import soa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  cmd_t               cmd,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CapW-1:0]    cfg_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [HandleW-1:0] alloc_handle,
	output logic [CntW-1:0]    slabs_in_use
);

	bstate_t            state_q, state_d;
	logic [CapW-1:0]    cfg_q;
	tag_t               tag_q   [NumSlabs];
	logic [CapW-1:0]    used_q  [NumSlabs];
	logic [CapW-1:0]    fresh_q [NumSlabs];
	logic [CapW-1:0]    top_q   [NumSlabs];
	logic [LinkW-1:0]   next_q  [NumSlabs];
	logic [LinkW-1:0]   prev_q  [NumSlabs];
	logic [LinkW-1:0]   head_q  [3];
	logic [CapW-1:0]    link_mem [MemDepth];
	logic [CapW-1:0]    mem_rdata_q;

	cmd_t               cmd_q;
	logic [SlabW-1:0]   s_q;
	logic [ObjW-1:0]    obj_q;
	tag_t               tgt_q;
	status_t            res_status_q;
	logic [HandleW-1:0] res_handle_q;

	logic               out_valid_q;
	status_t            status_q;
	logic [HandleW-1:0] handle_q;
	logic [CntW-1:0]    inuse_q;

	logic [CapW-1:0]    cap;
	logic               pick_valid;
	logic [SlabW-1:0]   pick_s;
	logic               any_unused;
	logic [SlabW-1:0]   low_unused;
	logic [CapW-1:0]    top_cur, fresh_cur, used_inc;
	tag_t               tgt_alloc;
	logic [SlabW-1:0]   fs;
	logic [ObjW-1:0]    fo;
	logic [CapW-1:0]    fused, fdec;
	tag_t               ftgt;
	tag_t               mv_old;
	logic [LinkW-1:0]   mv_p, mv_n, mv_h;
	logic [1:0]         old_idx, new_idx;
	logic               mv_do;
	logic [CntW-1:0]    inuse_cnt;
	logic               load_out;
	logic               mem_we;
	logic [HandleW-1:0] mem_waddr, mem_raddr;

	localparam logic [1:0] HeadEmpty   = 2'(TAG_EMPTY - 1);
	localparam logic [1:0] HeadPartial = 2'(TAG_PARTIAL - 1);

	assign cfg_ready = 1'b1;
	assign cap = (cfg_q > CapMax) ? CapMax : cfg_q;

	always_comb begin
		any_unused = 1'b0;
		low_unused = '0;
		for (int i = NumSlabs - 1; i >= 0; i--) begin
			if (tag_q[i] == TAG_UNUSED) begin
				any_unused = 1'b1;
				low_unused = SlabW'(i);
			end
		end
		if (!head_q[HeadPartial][SlabW]) begin
			pick_valid = (cap != '0);
			pick_s     = head_q[HeadPartial][SlabW-1:0];
		end else if (!head_q[HeadEmpty][SlabW]) begin
			pick_valid = (cap != '0);
			pick_s     = head_q[HeadEmpty][SlabW-1:0];
		end else begin
			pick_valid = (cap != '0) && any_unused;
			pick_s     = low_unused;
		end
	end

	always_comb begin
		top_cur   = top_q[s_q];
		fresh_cur = fresh_q[s_q];
		used_inc  = used_q[s_q] + CapW'(1);
		tgt_alloc = (used_inc >= cap) ? TAG_FULL : TAG_PARTIAL;
		fs        = cmd_q.handle[HandleW-1:ObjW];
		fo        = cmd_q.handle[ObjW-1:0];
		fused     = used_q[fs];
		fdec      = fused - CapW'(1);
		ftgt      = (fdec == '0) ? TAG_EMPTY : ((fdec >= cap) ? TAG_FULL : TAG_PARTIAL);
		mv_old    = tag_q[s_q];
		mv_p      = prev_q[s_q];
		mv_n      = next_q[s_q];
		old_idx   = 2'(mv_old - 2'd1);
		new_idx   = 2'(tgt_q - 2'd1);
		mv_h      = head_q[new_idx];
		mv_do     = (state_q == S_MOVE) && (mv_old != tgt_q);
		inuse_cnt = '0;
		for (int i = 0; i < NumSlabs; i++) begin
			inuse_cnt = inuse_cnt + CntW'(tag_q[i] != TAG_UNUSED);
		end
	end

	assign load_out  = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign mem_we    = (state_q == S_EXEC) && (cmd_q.op == OP_FREE) && (fused != '0);
	assign mem_waddr = {fs, fo};
	assign mem_raddr = {s_q, top_cur[ObjW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (cmd_q.op)
					OP_ALLOC: state_d = pick_valid ? S_TAKE : S_DONE;
					OP_FREE:  state_d = (fused == '0) ? S_DONE : S_MOVE;
					default:  state_d = S_DONE;
				endcase
			end
			S_TAKE: begin
				if (!top_cur[ObjW]) begin
					state_d = S_WAIT;
				end else if (fresh_cur < cap) begin
					state_d = S_MOVE;
				end else begin
					state_d = S_DONE;
				end
			end
			S_WAIT:  state_d = S_MOVE;
			S_MOVE:  state_d = S_DONE;
			S_DONE: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_waddr] <= top_q[fs];
		end
		mem_rdata_q <= link_mem[mem_raddr];
	end

	// slab state with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CapReset;
			for (int i = 0; i < NumSlabs; i++) begin
				tag_q[i]   <= TAG_UNUSED;
				used_q[i]  <= '0;
				fresh_q[i] <= '0;
				top_q[i]   <= ObjNone;
			end
			for (int j = 0; j < 3; j++) begin
				head_q[j] <= SlabNone;
			end
		end else begin
			if (cfg_valid) begin
				cfg_q <= cfg_data;
			end
			case (state_q)
				S_EXEC: begin
					case (cmd_q.op)
						OP_ALLOC: begin
							if (pick_valid && tag_q[pick_s] == TAG_UNUSED) begin
								used_q[pick_s]  <= '0;
								fresh_q[pick_s] <= '0;
								top_q[pick_s]   <= ObjNone;
							end
						end
						OP_FREE: begin
							if (fused != '0) begin
								top_q[fs]  <= {1'b0, fo};
								used_q[fs] <= fdec;
							end
						end
						OP_SHRINK: begin
							for (int i = 0; i < NumSlabs; i++) begin
								if (tag_q[i] == TAG_EMPTY) begin
									tag_q[i]   <= TAG_UNUSED;
									used_q[i]  <= '0;
									fresh_q[i] <= '0;
									top_q[i]   <= ObjNone;
								end
							end
							head_q[HeadEmpty] <= SlabNone;
						end
						default: begin
							for (int i = 0; i < NumSlabs; i++) begin
								tag_q[i]   <= TAG_UNUSED;
								used_q[i]  <= '0;
								fresh_q[i] <= '0;
								top_q[i]   <= ObjNone;
							end
							for (int j = 0; j < 3; j++) begin
								head_q[j] <= SlabNone;
							end
						end
					endcase
				end
				S_TAKE: begin
					if (top_cur[ObjW] && fresh_cur < cap) begin
						fresh_q[s_q] <= fresh_cur + CapW'(1);
						used_q[s_q]  <= used_inc;
					end
				end
				S_WAIT: begin
					top_q[s_q]  <= mem_rdata_q;
					used_q[s_q] <= used_inc;
				end
				S_MOVE: begin
					if (mv_do) begin
						if (mv_old != TAG_UNUSED && mv_p[SlabW]
							&& head_q[old_idx] == {1'b0, s_q}) begin
							head_q[old_idx] <= mv_n;
						end
						tag_q[s_q]      <= tgt_q;
						head_q[new_idx] <= {1'b0, s_q};
					end
				end
				default: ;
			endcase
		end
	end

	// slab links, undefined until written
	always_ff @(posedge clk) begin
		if (mv_do) begin
			if (mv_old != TAG_UNUSED) begin
				if (!mv_p[SlabW]) begin
					next_q[mv_p[SlabW-1:0]] <= mv_n;
				end
				if (!mv_n[SlabW]) begin
					prev_q[mv_n[SlabW-1:0]] <= mv_p;
				end
			end
			prev_q[s_q] <= SlabNone;
			next_q[s_q] <= mv_h;
			if (!mv_h[SlabW]) begin
				prev_q[mv_h[SlabW-1:0]] <= {1'b0, s_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q        <= cmd;
				res_status_q <= ST_OK;
				res_handle_q <= '0;
			end
			S_EXEC: begin
				if (cmd_q.op == OP_ALLOC) begin
					s_q <= pick_s;
					if (!pick_valid) begin
						res_status_q <= ST_OOM;
					end
				end else if (cmd_q.op == OP_FREE) begin
					s_q   <= fs;
					tgt_q <= ftgt;
					if (fused == '0) begin
						res_status_q <= ST_BAD;
					end
				end
			end
			S_TAKE: begin
				tgt_q <= tgt_alloc;
				if (!top_cur[ObjW]) begin
					obj_q <= top_cur[ObjW-1:0];
				end else if (fresh_cur < cap) begin
					obj_q <= fresh_cur[ObjW-1:0];
				end else begin
					res_status_q <= ST_OOM;
				end
			end
			S_MOVE: begin
				if (cmd_q.op == OP_ALLOC) begin
					res_handle_q <= {s_q, obj_q};
				end
			end
			default: ;
		endcase
		if (load_out) begin
			status_q <= res_status_q;
			handle_q <= res_handle_q;
			inuse_q  <= inuse_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = 2'(status_q);
	assign alloc_handle = handle_q;
	assign slabs_in_use = inuse_q;

`ifndef SYNTH
	a_handle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_OK |-> handle_q == '0)
		else $error("handle set on failed beat");
	a_move_tgt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MOVE |-> tgt_q != TAG_UNUSED)
		else $error("move to unused list");
	a_partial_head: assert property (@(posedge clk) disable iff (!arst_n)
		!head_q[HeadPartial][SlabW] |->
		tag_q[head_q[HeadPartial][SlabW-1:0]] == TAG_PARTIAL)
		else $error("partial head tag mismatch");
	a_inuse_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> inuse_q <= CntW'(NumSlabs))
		else $error("slab count out of range");
`endif

endmodule

/* rtl/slab_object_allocator.sv */
// Top level of the slab object allocator: front end, command queue and back end.
// Depends on soa_pkg, soa_front and soa_back.
//
//  channel | handshake              | payload
//  in      | in_valid / in_ready    | func, free_handle
//  out     | out_valid / out_ready  | status, alloc_handle, slabs_in_use
//  cfg     | cfg_valid / cfg_ready  | cfg_data (objects_per_slab)
//
// Back end takes one command at a time: alloc runs exec, take, wait (only for an object
// off a free stack, for the link memory read), move, done; free runs exec, move, done;
// failed alloc, bad free, shrink, release end early. A held result beat stalls the back end.
// Front queue holds two commands, so input beats keep landing while the back end works.
// Reset empties all lists; link memory needs no clearing. cfg is always ready.
module slab_object_allocator import soa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic [HandleW-1:0] free_handle,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [HandleW-1:0] alloc_handle,
	output logic [CntW-1:0]    slabs_in_use,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CapW-1:0]    cfg_data
);

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	soa_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.free_handle (free_handle),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd)
	);

	soa_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.alloc_handle (alloc_handle),
		.slabs_in_use (slabs_in_use)
	);

endmodule

/* bench/slab_object_allocator_tb.sv */
// Self-checking bench for slab_object_allocator: directed and random alloc, free,
// shrink and release beats checked against an in-bench allocator predictor.
// Depends on soa_pkg and the slab_object_allocator RTL.
module slab_object_allocator_tb import soa_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t            st;
		logic [HandleW-1:0] hdl;
		logic [CntW-1:0]    used;
	} alloc_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         func;
	logic [HandleW-1:0] free_handle;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic [HandleW-1:0] alloc_handle;
	logic [CntW-1:0]    slabs_in_use;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CapW-1:0]    cfg_data;

	slab_object_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .func(func), .free_handle(free_handle),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.alloc_handle(alloc_handle), .slabs_in_use(slabs_in_use),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// predictor state
	logic [CapW-1:0]  slab_cap_reg;
	tag_t             m_tag[NumSlabs];
	int unsigned      m_next[NumSlabs];
	int unsigned      m_prev[NumSlabs];
	int unsigned      m_head[3];
	int unsigned      m_used[NumSlabs];
	int unsigned      m_fresh[NumSlabs];
	int unsigned      m_top[NumSlabs];
	int unsigned      m_link[MemDepth];

	alloc_result_t    pending_results[$];
	int               error_count = 0;
	int               send_idle_pct = 0;
	int               recv_stall_pct = 0;
	int               hold_off_cycles = 0;
	logic [HandleW-1:0] live_handles[$];

	function automatic int unsigned eff_cap();
		return (slab_cap_reg > CapMax) ? int'(CapMax) : int'(slab_cap_reg);
	endfunction

	function automatic void slab_unlink(int unsigned s);
		int unsigned p, n;
		p = m_prev[s];
		n = m_next[s];
		if (m_tag[s] == TAG_UNUSED)
			return;
		if (p < NumSlabs)
			m_next[p] = n;
		else if (m_head[m_tag[s] - 1] == s)
			m_head[m_tag[s] - 1] = n;
		if (n < NumSlabs)
			m_prev[n] = p;
	endfunction

	function automatic void slab_move(int unsigned s, tag_t t);
		int unsigned h;
		if (m_tag[s] == t)
			return;
		slab_unlink(s);
		m_tag[s] = t;
		if (t == TAG_UNUSED)
			return;
		h = m_head[t - 1];
		m_prev[s] = NumSlabs;
		m_next[s] = h;
		if (h < NumSlabs)
			m_prev[h] = s;
		m_head[t - 1] = s;
	endfunction

	function automatic void slab_clear(int unsigned s);
		m_tag[s] = TAG_UNUSED;
		m_used[s] = 0;
		m_fresh[s] = 0;
		m_top[s] = 1 << ObjW;
	endfunction

	function automatic void alloc_model_reset();
		slab_cap_reg = CapReset;
		for (int i = 0; i < NumSlabs; i++) begin
			slab_clear(i);
			m_next[i] = 0;
			m_prev[i] = 0;
		end
		for (int i = 0; i < 3; i++)
			m_head[i] = NumSlabs;
	endfunction

	function automatic alloc_result_t alloc_predict(op_t op, logic [HandleW-1:0] fh);
		alloc_result_t r;
		int unsigned cap, s, o, n, cnt;
		cap = eff_cap();
		r.st = ST_OK;
		r.hdl = '0;
		case (op)
		OP_ALLOC: begin
			s = NumSlabs;
			if (m_head[TAG_PARTIAL - 1] < NumSlabs)
				s = m_head[TAG_PARTIAL - 1];
			else if (m_head[TAG_EMPTY - 1] < NumSlabs)
				s = m_head[TAG_EMPTY - 1];
			else if (cap > 0)
				for (int i = 0; i < NumSlabs && s == NumSlabs; i++)
					if (m_tag[i] == TAG_UNUSED)
						s = i;
			if (s >= NumSlabs || cap == 0) begin
				r.st = ST_OOM;
			end else begin
				if (m_tag[s] == TAG_UNUSED)
					slab_clear(s);
				if (m_top[s] < (1 << ObjW)) begin
					o = m_top[s];
					m_top[s] = m_link[(s << ObjW) + o];
				end else if (m_fresh[s] < cap) begin
					o = m_fresh[s];
					m_fresh[s]++;
				end else begin
					r.st = ST_OOM;
				end
				if (r.st == ST_OK) begin
					m_used[s]++;
					slab_move(s, (m_used[s] >= cap) ? TAG_FULL : TAG_PARTIAL);
					r.hdl = HandleW'((s << ObjW) + o);
				end
			end
		end
		OP_FREE: begin
			s = fh >> ObjW;
			o = fh & ((1 << ObjW) - 1);
			if (s >= NumSlabs || m_used[s] == 0) begin
				r.st = ST_BAD;
			end else begin
				m_link[(s << ObjW) + o] = m_top[s];
				m_top[s] = o;
				m_used[s]--;
				n = m_used[s];
				slab_move(s, (n == 0) ? TAG_EMPTY : ((n >= cap) ? TAG_FULL : TAG_PARTIAL));
			end
		end
		OP_SHRINK: begin
			for (int i = 0; i < NumSlabs; i++)
				if (m_tag[i] == TAG_EMPTY)
					slab_clear(i);
			m_head[TAG_EMPTY - 1] = NumSlabs;
		end
		default: begin
			for (int i = 0; i < NumSlabs; i++)
				slab_clear(i);
			for (int i = 0; i < 3; i++)
				m_head[i] = NumSlabs;
		end
		endcase
		cnt = 0;
		for (int i = 0; i < NumSlabs; i++)
			if (m_tag[i] != TAG_UNUSED)
				cnt++;
		r.used = CntW'(cnt);
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("FAILED: results differ");
		$finish;
	end

	// result checker
	always @(posedge clk) begin
		alloc_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result beat status=%0d handle=%0d", status, alloc_handle);
				error_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.st) begin
					$error("status expected %0d actual %0d", exp_r.st, status);
					error_count++;
				end
				if (alloc_handle !== exp_r.hdl) begin
					$error("alloc_handle expected %0d actual %0d", exp_r.hdl, alloc_handle);
					error_count++;
				end
				if (slabs_in_use !== exp_r.used) begin
					$error("slabs_in_use expected %0d actual %0d", exp_r.used, slabs_in_use);
					error_count++;
				end
			end
		end
	end

	// receiver stalls, with an optional long hold-off
	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// valid stays up between back-to-back beats; it drops only on idle or drain
	task automatic send_beat(op_t op, logic [HandleW-1:0] fh);
		alloc_result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		free_handle <= fh;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = alloc_predict(op, fh);
		pending_results.push_back(r);
		if (op == OP_ALLOC && r.st == ST_OK)
			live_handles.push_back(r.hdl);
		if (op == OP_RELEASE)
			live_handles.delete();
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_capacity(logic [CapW-1:0] v);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		slab_cap_reg = v;
		live_handles.delete();
		send_beat(OP_RELEASE, '0);
	endtask

	task automatic free_live(bit newest);
		int k;
		logic [HandleW-1:0] h;
		if (live_handles.size() == 0) begin
			send_beat(OP_FREE, HandleW'($urandom));
			return;
		end
		k = newest ? live_handles.size() - 1 : $urandom_range(live_handles.size() - 1);
		h = live_handles[k];
		live_handles.delete(k);
		send_beat(OP_FREE, h);
	endtask

	task automatic test_directed();
		send_beat(OP_FREE, '0);                // bad free on an empty pool
		send_beat(OP_FREE, '1);
		send_beat(OP_ALLOC, '0);
		send_beat(OP_ALLOC, '0);
		free_live(1'b0);                        // freed object comes back first
		send_beat(OP_ALLOC, '0);
		send_beat(OP_FREE, 14'h03FF);           // never handed out, pushed anyway
		send_beat(OP_ALLOC, '0);
		send_beat(OP_SHRINK, '0);
		send_beat(OP_RELEASE, '0);
		set_capacity('0);                       // zero capacity: alloc fails
		send_beat(OP_ALLOC, '0);
		set_capacity(11'h7FF);                  // saturates at the maximum
		send_beat(OP_ALLOC, '0);
		set_capacity(11'd1);
		for (int i = 0; i < NumSlabs + 1; i++)
			send_beat(OP_ALLOC, '0);            // fill the pool, then out of memory
		free_live(1'b0);
		send_beat(OP_SHRINK, '0);
		set_capacity(11'd3);
		for (int i = 0; i < 3; i++)
			send_beat(OP_ALLOC, '0);
		drain_results();
		slab_cap_reg = 11'd2;                   // shrink capacity under a full slab
		cfg_valid <= 1'b1;
		cfg_data <= 11'd2;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		free_live(1'b1);
		send_beat(OP_ALLOC, '0);
	endtask

	task automatic random_phase(int n, int idle, int stall);
		int r;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 50)
				send_beat(OP_ALLOC, HandleW'($urandom));
			else if (r < 85)
				free_live(r[0]);
			else if (r < 92)
				send_beat(OP_FREE, HandleW'($urandom));
			else if (r < 97)
				send_beat(OP_SHRINK, HandleW'($urandom));
			else
				send_beat(OP_RELEASE, HandleW'($urandom));
		end
	endtask

	task automatic test_random();
		logic [CapW-1:0] caps[6] = '{11'd4, 11'd1, 11'd2, 11'd37, 11'd1024, 11'd1500};
		for (int c = 0; c < 6; c++) begin
			set_capacity(caps[c]);
			random_phase(50, 0, 0);
			random_phase(50, 59, 0);
			random_phase(50, 0, 59);
			random_phase(50, 21, 21);
		end
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain_results();
		hold_off_cycles = 200;
		for (int i = 0; i < 12; i++)
			send_beat(OP_ALLOC, '0);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = OP_ALLOC;
		free_handle = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		alloc_model_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random();
		drain_results();
		if (error_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

/* slab_object_allocator.f */
rtl/soa_pkg.sv
rtl/soa_front.sv
rtl/soa_back.sv
rtl/slab_object_allocator.sv
bench/slab_object_allocator_tb.sv
